@@ rtl/core/clas_pkg.sv @@
// shared types, constants and defaults for the command line argument splitter
package clas_pkg;

  // parameter defaults
  localparam int MAX_RUN_DEF     = 31;
  localparam int CHAR_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // widths fixed by the field list
  localparam int CH_W    = 16;
  localparam int CNT_W   = 16;
  localparam int FLUSH_W = 6;

  // character codes
  localparam logic [CH_W-1:0] CH_QUOTE  = 16'h0022;
  localparam logic [CH_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CH_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [CH_W-1:0] CH_TAB    = 16'h0009;
  localparam logic [CH_W-1:0] CH_NUL    = 16'h0000;

  // result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_ARG  = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // one classified character: backslashes to flush, then the tail results
  typedef struct packed {
    logic [FLUSH_W-1:0] flush;
    logic               emit;
    logic               end_arg;
    logic               end_line;
    logic [CH_W-1:0]    chr;
    logic               ovf;
    logic [CNT_W-1:0]   arg_total;
    logic [CNT_W-1:0]   char_total;
  } entry_t;

endpackage

@@ rtl/core/clas_front.sv @@
// front part: takes characters, runs the splitting rules and queues work
module clas_front #(
  parameter int MAX_RUN   = 31,
  parameter int CHAR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ch_valid,
  output logic                  ch_stall,
  input  logic [15:0]           ch,
  input  logic                  q_full,
  output logic                  push,
  output clas_pkg::entry_t      entry
);
  import clas_pkg::*;

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  logic             first_arg_mode, first_arg_mode_next;
  logic             quoted, quoted_next;
  logic             quote_pending, quote_pending_next;
  logic             inside_arg, inside_arg_next;
  logic [RUN_W-1:0] slash_run, slash_run_next;
  logic             overflow_seen, overflow_seen_next;
  logic [CNT_W-1:0] arg_counter, arg_counter_next;
  logic [CNT_W-1:0] char_counter, char_counter_next;

  logic             accept;
  logic [CH_W-1:0]  c;
  logic             is_q, is_bs, is_nul, is_blank;
  logic [CNT_W:0]   char_sum;

  assign ch_stall = q_full;
  assign accept   = ch_valid && !q_full;

  // character class
  assign c        = CH_W'(ch[CHAR_BITS-1:0]);
  assign is_q     = (c == CH_QUOTE);
  assign is_bs    = (c == CH_BSLASH);
  assign is_nul   = (c == CH_NUL);
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB);

  // splitting rules and the saturating totals after this character
  always_comb begin
    logic done;
    done                = 1'b0;
    first_arg_mode_next = first_arg_mode;
    quoted_next         = quoted;
    quote_pending_next  = quote_pending;
    inside_arg_next     = inside_arg;
    slash_run_next      = slash_run;
    overflow_seen_next  = overflow_seen;
    entry.flush         = '0;
    entry.emit          = 1'b0;
    entry.end_arg       = 1'b0;
    entry.end_line      = 1'b0;
    entry.chr           = c;
    if (first_arg_mode) begin
      if (is_q) begin
        quoted_next = !quoted;
      end else if (is_nul) begin
        entry.end_arg  = 1'b1;
        entry.end_line = 1'b1;
      end else if (!quoted && is_blank) begin
        entry.end_arg       = 1'b1;
        first_arg_mode_next = 1'b0;
        quoted_next         = 1'b0;
      end else begin
        entry.emit = 1'b1;
      end
    end else begin
      // settle a quote seen inside quotes
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (is_q) begin
          entry.emit = 1'b1;
          entry.chr  = CH_QUOTE;
          done       = 1'b1;
        end else begin
          quoted_next = 1'b0;
        end
      end
      // backslash run, saturating
      if (!done && is_bs) begin
        inside_arg_next = 1'b1;
        if (slash_run < RUN_W'(MAX_RUN)) begin
          slash_run_next = slash_run + 1'b1;
        end else begin
          overflow_seen_next = 1'b1;
        end
        done = 1'b1;
      end
      // between arguments
      if (!done && !inside_arg) begin
        if (is_blank) begin
          done = 1'b1;
        end else if (is_nul) begin
          entry.end_line = 1'b1;
          done           = 1'b1;
        end else begin
          inside_arg_next = 1'b1;
        end
      end
      // inside an argument
      if (!done) begin
        slash_run_next = '0;
        if (is_q) begin
          entry.flush = FLUSH_W'(slash_run >> 1);
          if (slash_run[0]) begin
            entry.emit = 1'b1;
            entry.chr  = CH_QUOTE;
          end else if (quoted_next) begin
            quote_pending_next = 1'b1;
          end else begin
            quoted_next = 1'b1;
          end
        end else begin
          entry.flush = FLUSH_W'(slash_run);
          if (is_nul) begin
            entry.end_arg  = 1'b1;
            entry.end_line = 1'b1;
          end else if (!quoted_next && is_blank) begin
            entry.end_arg   = 1'b1;
            inside_arg_next = 1'b0;
          end else begin
            entry.emit = 1'b1;
          end
        end
      end
    end

    // saturating totals
    char_sum = (CNT_W+1)'(char_counter) + (CNT_W+1)'(entry.flush)
             + (CNT_W+1)'(entry.emit) + (CNT_W+1)'(entry.end_arg);
    if (char_sum > (CNT_W+1)'(CNT_MAX)) begin
      char_counter_next = CNT_MAX;
    end else begin
      char_counter_next = char_sum[CNT_W-1:0];
    end
    if (entry.end_arg && (arg_counter != CNT_MAX)) begin
      arg_counter_next = arg_counter + 1'b1;
    end else begin
      arg_counter_next = arg_counter;
    end
    entry.ovf        = overflow_seen_next;
    entry.arg_total  = arg_counter_next;
    entry.char_total = char_counter_next;
  end

  assign push = accept && ((entry.flush != '0) || entry.emit || entry.end_arg
                           || entry.end_line);

  // state registers, back to reset at the end of a line
  always_ff @(posedge clk) begin
    if (rst || (accept && entry.end_line)) begin
      first_arg_mode <= 1'b1;
      quoted         <= 1'b0;
      quote_pending  <= 1'b0;
      inside_arg     <= 1'b0;
      slash_run      <= '0;
      overflow_seen  <= 1'b0;
      arg_counter    <= '0;
      char_counter   <= '0;
    end else if (accept) begin
      first_arg_mode <= first_arg_mode_next;
      quoted         <= quoted_next;
      quote_pending  <= quote_pending_next;
      inside_arg     <= inside_arg_next;
      slash_run      <= slash_run_next;
      overflow_seen  <= overflow_seen_next;
      arg_counter    <= arg_counter_next;
      char_counter   <= char_counter_next;
    end
  end

endmodule

@@ rtl/core/clas_fifo.sv @@
// short queue of classified characters between front and back
module clas_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  clas_pkg::entry_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output clas_pkg::entry_t rd_data
);
  import clas_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/clas_back.sv @@
// back part: expands queued work into one result per cycle while the output is not stalled
module clas_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  clas_pkg::entry_t q_data,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [1:0]       kind,
  output logic [15:0]      out_char,
  output logic [15:0]      arg_total,
  output logic [15:0]      char_total,
  output logic             run_overflow,
  output logic             last
);
  import clas_pkg::*;

  entry_t           work;
  logic             busy;
  logic             res_free;
  logic             produce;
  logic             fin;
  logic [1:0]       k;
  logic [CH_W-1:0]  chr;
  logic             clr_emit, clr_arg;

  assign res_free = !res_valid || !res_stall;
  assign produce  = res_free && busy;
  assign pop      = q_valid && (!busy || (produce && fin));

  // next result of the work in hand
  always_comb begin
    chr      = CH_NUL;
    clr_emit = 1'b0;
    clr_arg  = 1'b0;
    if (work.flush != '0) begin
      k   = KIND_CHAR;
      chr = CH_BSLASH;
      fin = (work.flush == FLUSH_W'(1)) && !work.emit && !work.end_arg && !work.end_line;
    end else if (work.emit) begin
      k        = KIND_CHAR;
      chr      = work.chr;
      clr_emit = 1'b1;
      fin      = !work.end_arg && !work.end_line;
    end else if (work.end_arg) begin
      k       = KIND_ARG;
      clr_arg = 1'b1;
      fin     = !work.end_line;
    end else begin
      k   = KIND_LINE;
      fin = 1'b1;
    end
  end

  // work register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (produce) begin
        res_valid <= 1'b1;
      end else if (res_free) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        work <= q_data;
      end else begin
        if (produce && fin) begin
          busy <= 1'b0;
        end
        if (produce) begin
          if (work.flush != '0) begin
            work.flush <= work.flush - 1'b1;
          end
          if (clr_emit) begin
            work.emit <= 1'b0;
          end
          if (clr_arg) begin
            work.end_arg <= 1'b0;
          end
        end
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (produce) begin
      kind         <= k;
      out_char     <= chr;
      arg_total    <= (k == KIND_LINE) ? work.arg_total : '0;
      char_total   <= (k == KIND_LINE) ? work.char_total : '0;
      run_overflow <= work.ovf;
      last         <= fin;
    end
  end

endmodule

@@ rtl/core/command_line_argument_splitter.sv @@
// top level of the command line argument splitter
// path: a result passes through the queue, the back part's work register and the output register
// throughput: one character per cycle while each makes at most one result and the output is
//   not stalled; a character that flushes n backslashes makes n plus its tail results in turn
// the four-entry queue lets the front keep taking characters while the back part expands them
// reset: synchronous, clears splitter state, queue and output valid; no clearing pass
module command_line_argument_splitter #(
  parameter int MAX_RUN     = clas_pkg::MAX_RUN_DEF,
  parameter int CHAR_BITS   = clas_pkg::CHAR_BITS_DEF,
  parameter int QUEUE_DEPTH = clas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ch_valid,
  output logic        ch_stall,
  input  logic [15:0] ch,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [15:0] out_char,
  output logic [15:0] arg_total,
  output logic [15:0] char_total,
  output logic        run_overflow,
  output logic        last
);
  import clas_pkg::*;

  entry_t push_data;
  entry_t q_data;
  logic   push;
  logic   q_full;
  logic   q_valid;
  logic   pop;

  // classify characters
  clas_front #(
    .MAX_RUN   (MAX_RUN),
    .CHAR_BITS (CHAR_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .ch_valid (ch_valid),
    .ch_stall (ch_stall),
    .ch       (ch),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_data)
  );

  // decoupling queue
  clas_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (push_data),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  // expand into results
  clas_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .out_char     (out_char),
    .arg_total    (arg_total),
    .char_total   (char_total),
    .run_overflow (run_overflow),
    .last         (last)
  );

  // end of line always closes the results of its character
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_LINE) |-> last)
    else $error("end of line result without last");

  // totals only on the end of line
  a_totals_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind != KIND_LINE) |-> (arg_total == '0) && (char_total == '0))
    else $error("totals on a result that is not end of line");

  // only character results carry a character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind != KIND_CHAR) |-> (out_char == '0))
    else $error("character on a mark result");

  // kind stays within its codes
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (kind == KIND_CHAR) || (kind == KIND_ARG) || (kind == KIND_LINE))
    else $error("unknown result kind");

endmodule

@@ bench/tb_command_line_argument_splitter.sv @@
// testbench for the command line argument splitter: directed and random lines checked per result
module tb_command_line_argument_splitter;
  import clas_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SPLIT_RUN   = MAX_RUN_DEF;
  localparam logic [15:0] CHAR_MASK   = 16'((32'd1 << CHAR_BITS_DEF) - 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] chr;
    logic [15:0] args;
    logic [15:0] chars;
    logic        ovf;
    logic        last;
  } split_piece_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        ch_valid = 1'b0;
  logic        ch_stall;
  logic [15:0] ch = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] out_char;
  logic [15:0] arg_total;
  logic [15:0] char_total;
  logic        run_overflow;
  logic        last;

  command_line_argument_splitter dut (
    .clk(clk), .rst(rst),
    .ch_valid(ch_valid), .ch_stall(ch_stall), .ch(ch),
    .res_valid(res_valid), .res_stall(res_stall),
    .kind(kind), .out_char(out_char), .arg_total(arg_total),
    .char_total(char_total), .run_overflow(run_overflow), .last(last)
  );

  always #1 clk = ~clk;

  // characters waiting to be offered and results still owed by the block
  logic [15:0]  line_chars [$];
  split_piece_t expected_pieces [$];
  int           queued_items = 0;
  int           mismatches = 0;
  int           cycles = 0;
  bit           no_idle = 1'b0;
  int           hold_asks = 0;
  int           hold_done = 0;

  // splitter state mirrored by the predictor
  bit          first_mode;
  bit          in_quotes;
  bit          quote_wait;
  bit          in_arg;
  bit          run_clipped;
  logic [5:0]  bs_run;
  logic [15:0] arg_cnt;
  logic [15:0] char_cnt;

  logic [15:0] directed_chars [$] = {
    CH_NUL,
    CH_QUOTE, 16'h0070, CH_SPACE, 16'h0071, CH_QUOTE, CH_TAB,
    CH_BSLASH, CH_BSLASH, CH_QUOTE, 16'h0061, CH_QUOTE, CH_QUOTE, CH_QUOTE, 16'h0062, CH_SPACE,
    CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_QUOTE,
    16'hFFFF, 16'h0001, CH_QUOTE, CH_NUL
  };

  function automatic void clear_splitter();
    first_mode  = 1'b1;
    in_quotes   = 1'b0;
    quote_wait  = 1'b0;
    in_arg      = 1'b0;
    run_clipped = 1'b0;
    bs_run      = '0;
    arg_cnt     = '0;
    char_cnt    = '0;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic bit is_blank(logic [15:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic void add_piece(logic [1:0] k, logic [15:0] c, logic [15:0] a,
                                    logic [15:0] n);
    split_piece_t p;
    p.kind  = k;
    p.chr   = c;
    p.args  = a;
    p.chars = n;
    p.ovf   = run_clipped;
    p.last  = 1'b0;
    expected_pieces.push_back(p);
  endfunction

  function automatic void emit_char(logic [15:0] c);
    char_cnt = sat_add(char_cnt);
    add_piece(KIND_CHAR, c, '0, '0);
  endfunction

  function automatic void close_arg();
    char_cnt = sat_add(char_cnt);
    arg_cnt  = sat_add(arg_cnt);
    add_piece(KIND_ARG, '0, '0, '0);
  endfunction

  function automatic void close_line();
    add_piece(KIND_LINE, '0, arg_cnt, char_cnt);
    clear_splitter();
  endfunction

  function automatic void flush_bslashes(int count);
    for (int i = 0; i < count; i++) emit_char(CH_BSLASH);
    bs_run = '0;
  endfunction

  // expected results of one accepted character
  function automatic void split_char(logic [15:0] raw);
    logic [15:0]  c;
    int           start;
    int           run;
    bit           done;
    split_piece_t tail;
    c     = raw & CHAR_MASK;
    start = expected_pieces.size();
    done  = 1'b0;
    if (first_mode) begin
      // program name: quotes only toggle, backslashes are literal
      if (c == CH_QUOTE) begin
        in_quotes = !in_quotes;
      end else if (c == CH_NUL) begin
        close_arg();
        close_line();
      end else if (!in_quotes && is_blank(c)) begin
        close_arg();
        first_mode = 1'b0;
        in_quotes  = 1'b0;
      end else begin
        emit_char(c);
      end
    end else begin
      // a quote seen inside quotes is settled by the next character
      if (quote_wait) begin
        quote_wait = 1'b0;
        if (c == CH_QUOTE) begin
          emit_char(CH_QUOTE);
          done = 1'b1;
        end else begin
          in_quotes = 1'b0;
        end
      end
      if (!done && c == CH_BSLASH) begin
        in_arg = 1'b1;
        if (bs_run < SPLIT_RUN) bs_run = bs_run + 6'd1;
        else run_clipped = 1'b1;
        done = 1'b1;
      end
      if (!done && !in_arg) begin
        if (is_blank(c)) begin
          done = 1'b1;
        end else if (c == CH_NUL) begin
          close_line();
          done = 1'b1;
        end else begin
          in_arg = 1'b1;
        end
      end
      if (!done) begin
        if (c == CH_QUOTE) begin
          run = bs_run;
          flush_bslashes(run >> 1);
          if (run % 2 == 1) emit_char(CH_QUOTE);
          else if (in_quotes) quote_wait = 1'b1;
          else in_quotes = 1'b1;
        end else begin
          flush_bslashes(bs_run);
          if (c == CH_NUL) begin
            close_arg();
            close_line();
          end else if (!in_quotes && is_blank(c)) begin
            close_arg();
            in_arg = 1'b0;
          end else begin
            emit_char(c);
          end
        end
      end
    end
    if (expected_pieces.size() > start) begin
      tail = expected_pieces.pop_back();
      tail.last = 1'b1;
      expected_pieces.push_back(tail);
    end
  endfunction

  // stimulus helpers
  function automatic void offer_char(logic [15:0] c);
    line_chars.push_back(c);
    queued_items++;
  endfunction

  function automatic logic [15:0] pick_char();
    case ($urandom_range(0, 9))
      0:       return CH_QUOTE;
      1:       return CH_SPACE;
      2:       return CH_TAB;
      3:       return 16'($urandom_range(1, 16'hFFFF));
      default: return 16'h0061 + 16'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [15:0] pick_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  // one well-formed line with random content
  function automatic void queue_line(bit long_run);
    int len;
    int run;
    len = $urandom_range(0, 5);
    repeat (len) offer_char($urandom_range(0, 6) == 0 ? CH_BSLASH : pick_char());
    if ($urandom_range(0, 9) == 0) begin
      offer_char(CH_NUL);
      return;
    end
    offer_char(pick_blank());
    repeat ($urandom_range(0, 4)) begin
      repeat ($urandom_range(0, 2)) offer_char(pick_blank());
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          run = (long_run || $urandom_range(0, 19) == 0) ? $urandom_range(28, 40)
                                                          : $urandom_range(1, 4);
          repeat (run) offer_char(CH_BSLASH);
        end
        offer_char(pick_char());
      end
      offer_char(pick_blank());
    end
    offer_char(CH_NUL);
  endfunction

  // broken line: raw characters over the full range
  function automatic void queue_noise();
    repeat ($urandom_range(1, 8)) offer_char(16'($urandom_range(0, 16'hFFFF)));
  endfunction

  function automatic void queue_mix(int target, bit long_run);
    while (queued_items < target) begin
      if ($urandom_range(0, 4) == 0) queue_noise();
      else queue_line(long_run);
    end
  endfunction

  task automatic wait_drained();
    while (line_chars.size() != 0 || ch_valid || expected_pieces.size() != 0)
      @(posedge clk);
  endtask

  // sender: offers queued characters, holds a stalled transfer steady
  int src_gap = 0;
  int src_calm = 0;
  bit src_busy;

  always @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
      src_gap = 0;
    end else begin
      src_busy = ch_valid && ch_stall;
      if (ch_valid && !ch_stall) split_char(ch);
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap--;
          ch_valid <= 1'b0;
        end else begin
          if (src_calm > 0) src_calm--;
          else if (!no_idle && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 16);
          else if ($urandom_range(0, 39) == 0) src_calm = $urandom_range(30, 120);
          if (src_gap == 0 && line_chars.size() > 0) begin
            ch_valid <= 1'b1;
            ch <= line_chars.pop_front();
          end else begin
            ch_valid <= 1'b0;
            if (src_gap > 0) src_gap--;
          end
        end
      end
    end
  end

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // receiver: checks each result transfer and stalls in bursts or long holds
  int           sink_gap = 0;
  int           sink_calm = 0;
  int           hold_left = 0;
  split_piece_t want;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_pieces.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got kind %0d char %h",
                   $time, kind, out_char);
        end else begin
          want = expected_pieces.pop_front();
          compare_field("kind", 16'(want.kind), 16'(kind));
          compare_field("out_char", want.chr, out_char);
          compare_field("arg_total", want.args, arg_total);
          compare_field("char_total", want.chars, char_total);
          compare_field("run_overflow", 16'(want.ovf), 16'(run_overflow));
          compare_field("last", 16'(want.last), 16'(last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (hold_asks != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES - 1;
        res_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        res_stall <= 1'b1;
      end else begin
        if (sink_calm > 0) sink_calm--;
        else if (!no_idle && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 16);
        else if ($urandom_range(0, 39) == 0) sink_calm = $urandom_range(30, 120);
        res_stall <= (sink_gap > 0);
        if (sink_gap > 0) sink_gap--;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin
    clear_splitter();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty line, quoted program name, backslash and quote rules,
    // extreme characters, unclosed quote
    foreach (directed_chars[i]) offer_char(directed_chars[i]);
    wait_drained();

    // long receiver hold while long backslash runs pile up behind it
    hold_asks++;
    queue_mix(70, 1'b1);
    wait_drained();

    // random lines and noise with idling on both sides
    queue_mix(190, 1'b0);
    wait_drained();

    // final stretch with no idling
    no_idle = 1'b1;
    queue_mix(260, 1'b0);
    wait_drained();
    repeat (12) @(posedge clk);

    if (mismatches == 0 && expected_pieces.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/clas_pkg.sv
rtl/core/clas_front.sv
rtl/core/clas_fifo.sv
rtl/core/clas_back.sv
rtl/core/command_line_argument_splitter.sv
bench/tb_command_line_argument_splitter.sv
